// ===== rtl/core/fir_lowpass_25tap_defines.svh =====
// Assertion macros shared by the low-pass FIR RTL.
// No dependencies; included by files that carry checks.
`ifndef FIR_LOWPASS_25TAP_DEFINES_SVH
`define FIR_LOWPASS_25TAP_DEFINES_SVH

`ifndef SYNTHESIS
// check with reset held off
`define FLP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds through reset
`define FLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLP_ASSERT(lbl, clk, rst, prop, msg)
`define FLP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/fir_lp_pkg.sv =====
// Shared widths and the coefficient table of the low-pass FIR: Q1.15 values held in 13 signed bits.
// No dependencies.
package fir_lp_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 13;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = 34;
  localparam int FRAC_BITS  = 15;
  localparam int COEF_COUNT = 25;
  localparam int COEF_IDX_W = $clog2(COEF_COUNT);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam coef_t COEF_TABLE [COEF_COUNT] = '{
    13'sd26,   13'sd77,   13'sd175,  13'sd336,  13'sd571,  13'sd885,
    13'sd1267, 13'sd1696, 13'sd2138, 13'sd2548, 13'sd2883, 13'sd3101,
    13'sd3178,
    13'sd3101, 13'sd2883, 13'sd2548, 13'sd2138, 13'sd1696, 13'sd1267,
    13'sd885,  13'sd571,  13'sd336,  13'sd175,  13'sd77,   13'sd26
  };

  // taps past the table have a zero weight
  function automatic coef_t coef_at(input int unsigned i);
    logic [COEF_IDX_W-1:0] idx;
    idx = i[COEF_IDX_W-1:0];
    if (i < COEF_COUNT) begin
      return COEF_TABLE[idx];
    end
    return '0;
  endfunction

endpackage

// ===== rtl/core/fir_lp_cell.sv =====
// One tap of the transposed FIR chain: multiply, add the neighbor's sum, register.
// Depends on fir_lp_pkg.
module fir_lp_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  fir_lp_pkg::sample_t x,
  input  fir_lp_pkg::acc_t  sum_in,
  output fir_lp_pkg::acc_t  sum_out
);

  localparam fir_lp_pkg::coef_t COEF = fir_lp_pkg::coef_at(IDX);
  localparam int EXT_W = fir_lp_pkg::ACC_W - fir_lp_pkg::PROD_W;

  fir_lp_pkg::prod_t prod;
  fir_lp_pkg::acc_t  sum;
  fir_lp_pkg::acc_t  sum_next;

  assign prod     = x * COEF;
  assign sum_next = {{EXT_W{prod[fir_lp_pkg::PROD_W-1]}}, prod} + sum_in;
  assign sum_out  = sum;

  // partial sums stand for the delay line, so reset clears them
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (en) begin
      sum <= sum_next;
    end
  end

endmodule

// ===== rtl/core/fir_lp_sat.sv =====
// Scales the Q19.15 sum back to a sample: shift by 15 toward zero, clamp to 16 bits.
// Depends on fir_lp_pkg.
module fir_lp_sat (
  input  fir_lp_pkg::acc_t    acc,
  output fir_lp_pkg::sample_t sample
);

  localparam int Q_W = fir_lp_pkg::ACC_W - fir_lp_pkg::FRAC_BITS;
  localparam int HI  = (1 << (fir_lp_pkg::SAMPLE_W - 1)) - 1;
  localparam fir_lp_pkg::acc_t BIAS = fir_lp_pkg::ACC_W'((1 << fir_lp_pkg::FRAC_BITS) - 1);

  fir_lp_pkg::acc_t      biased;
  logic signed [Q_W-1:0] q;

  // bias negative sums so the arithmetic shift truncates toward zero
  assign biased = acc + (acc[fir_lp_pkg::ACC_W-1] ? BIAS : '0);
  assign q      = biased[fir_lp_pkg::ACC_W-1:fir_lp_pkg::FRAC_BITS];

  always_comb begin
    if (q > Q_W'(HI)) begin
      sample = fir_lp_pkg::SAMPLE_W'(HI);
    end else if (q < -Q_W'(HI) - Q_W'(1)) begin
      sample = fir_lp_pkg::SAMPLE_W'(-HI - 1);
    end else begin
      sample = q[fir_lp_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/core/fir_lowpass_25tap.sv =====
// Transposed-form low-pass FIR: one signed 16-bit word in, one filtered word out.
// A word is taken on every clock while the output register is empty or being
// read, and its result stands at the output in the next cycle; the rate is set by
// the single multiply-add in each cell of the chain. The chain of TAPS cells
// holds running partial sums instead of past samples, and reset clears them,
// which matches an all-zero history. Cell 0 is the output register.
// Depends on fir_lp_pkg, fir_lp_cell, fir_lp_sat.
`include "fir_lowpass_25tap_defines.svh"

module fir_lowpass_25tap #(
  parameter int unsigned TAPS = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sample_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] sample_out
);

  fir_lp_pkg::acc_t sums [TAPS+1];
  logic             accept;

  assign in_ready    = !out_valid || out_ready;
  assign accept      = in_valid && in_ready;
  assign sums[TAPS]  = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    fir_lp_cell #(.IDX(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (accept),
      .x       (sample_in),
      .sum_in  (sums[k+1]),
      .sum_out (sums[k])
    );
  end

  fir_lp_sat u_sat (
    .acc    (sums[0]),
    .sample (sample_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `FLP_ASSERT(a_accept_gives_word, clk, rst, accept |=> out_valid,
              "accepted word gave no result")
  `FLP_ASSERT(a_no_overwrite, clk, rst, (out_valid && !out_ready) |-> !in_ready,
              "unread word could be overwritten")
  `FLP_ASSERT(a_chain_holds, clk, rst, !accept |=> $stable(sums[0]),
              "chain moved without an accepted word")
  `FLP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid right after reset")

endmodule
